// ===== src/mnet_pkg.sv =====
// Shared types, constants and arithmetic helpers for the MIDI note event tracker.
package mnet_pkg;

   localparam int unsigned EVENT_CAPACITY_DEFAULT = 64;

   localparam int unsigned STATUS_W   = 8;
   localparam int unsigned KEY_W      = 8;
   localparam int unsigned NOTE_W     = 7;
   localparam int unsigned VEL_W      = 7;
   localparam int unsigned CHAN_W     = 4;
   localparam int unsigned TIME_W     = 48;
   localparam int unsigned ACTION_W   = 2;
   localparam int unsigned EVIDX_W    = 6;
   localparam int unsigned FREQ_W     = 30;
   localparam int unsigned LEVEL_W    = 16;
   localparam int unsigned FILTER_W   = 5;
   localparam int unsigned SAMPLE_W   = 25;
   localparam int unsigned NOTE_COUNT = 128;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 64;

   // upper nibble of the status byte
   localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
   localparam logic [3:0] MSG_NOTE_ON  = 4'h9;

   localparam logic [FILTER_W-1:0] FILTER_RESET      = 5'd0;
   localparam logic [SAMPLE_W-1:0] ONE_SAMPLE_RESET  = 25'd699;
   localparam logic [TIME_W-1:0]   HELD_DUR_RESET    = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [ACTION_W-1:0] {
      ACT_IGNORED  = 2'd0,
      ACT_RECORDED = 2'd1,
      ACT_DROPPED  = 2'd2,
      ACT_CLOSED   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_CHANNEL_FILTER = 2'd0,
      CSR_ONE_SAMPLE     = 2'd1,
      CSR_HELD_DURATION  = 2'd2
   } csr_reg_type;

   // top octave (notes 120..131) in Hz, Q14.16
   localparam logic [FREQ_W-1:0] TOP_OCTAVE_Q16 [12] = '{
      30'd548668578, 30'd581294109, 30'd615859655, 30'd652480576,
      30'd691279090, 30'd732384684, 30'd775934544, 30'd822074013,
      30'd870957077, 30'd922746880, 30'd977616265, 30'd1035748353
   };

   // ceil(2^29 / 127): exact quotient for dividends below 2^22
   localparam logic [22:0] VEL_RECIP = 23'd4227331;

   function automatic logic [FREQ_W-1:0] note_freq(input logic [NOTE_W-1:0] note);
      logic [12:0] prod;
      logic [3:0]  octave;
      logic [6:0]  semi;
      logic [3:0]  sh;
      logic [30:0] t;
      prod   = 13'(note) * 13'd43;       // note / 12 for note < 128
      octave = prod[12:9];
      semi   = note - 7'(7'(octave) * 7'd12);
      sh     = 4'd10 - octave;
      t      = {1'b0, TOP_OCTAVE_Q16[semi[3:0]]};
      if (sh != 4'd0) begin
         t = (t + (31'd1 << (sh - 4'd1))) >> sh;
      end
      return t[FREQ_W-1:0];
   endfunction

   // round(v * 32768 / 127)
   function automatic logic [LEVEL_W-1:0] vel_level(input logic [VEL_W-1:0] vel);
      logic [21:0] num;
      logic [44:0] prod;
      num  = {vel, 15'd0} + 22'd63;
      prod = 45'(num) * 45'(VEL_RECIP);
      return prod[44:29];
   endfunction

endpackage

// ===== src/mnet_req_if.sv =====
// Request channel: one raw MIDI event with the current beat time.
interface mnet_req_if;
   import mnet_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] midi_status;
   logic [KEY_W-1:0]    key_byte;
   logic [VEL_W-1:0]    velocity_byte;
   logic [CHAN_W-1:0]   midi_channel;
   logic [TIME_W-1:0]   time_beats;

   modport source (
      output valid, midi_status, key_byte, velocity_byte, midi_channel, time_beats,
      input  ready
   );

   modport sink (
      input  valid, midi_status, key_byte, velocity_byte, midi_channel, time_beats,
      output ready
   );
endinterface

// ===== src/mnet_rsp_if.sv =====
// Response channel: one tracker result per request.
interface mnet_rsp_if;
   import mnet_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [EVIDX_W-1:0]  event_index;
   logic [TIME_W-1:0]   start_time;
   logic [TIME_W-1:0]   note_duration;
   logic [FREQ_W-1:0]   frequency_hz;
   logic [LEVEL_W-1:0]  velocity_level;
   logic [NOTE_W-1:0]   note_number;

   modport source (
      output valid, action, event_index, start_time, note_duration, frequency_hz,
             velocity_level, note_number,
      input  ready
   );

   modport sink (
      input  valid, action, event_index, start_time, note_duration, frequency_hz,
             velocity_level, note_number,
      output ready
   );
endinterface

// ===== src/midi_note_event_tracker_top.sv =====
// MIDI note-on/note-off tracker: link table, record counter and CSR block.
//
// Usage
//  - req_if carries one raw MIDI event (status, key, velocity, channel) plus
//    the current time in beats (Q24.24). rsp_if returns exactly one result
//    per request: ignored, note-on recorded, note-on dropped (list full) or
//    duration set, with start time, duration, frequency (Q14.16), velocity
//    level (Q1.15) and note number.
//  - Configuration is written over the APB-style csr_ port (64-bit data,
//    registers at byte offsets 0, 8, 16) while no request is in flight.
//  - A request's fields and its link are registered into the compute stage on
//    acceptance, by a registered read of the link memory; on retire the stage
//    writes the link back and its result into the output register.
//  - req_if.ready drops from acceptance until retire only; a new request is
//    taken while the previous response still waits in the output register.
//  - If rsp_if stalls, the in-flight request holds in the compute stage until
//    the output register frees, then req_if.ready returns.
//  - Reset clears the config registers to their defaults, the record count to
//    zero and all 128 note links to none (valid flags, no clearing pass).
module midi_note_event_tracker_top #(
   parameter int unsigned EVENT_CAPACITY = mnet_pkg::EVENT_CAPACITY_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   mnet_req_if.sink                         req_if,
   mnet_rsp_if.source                       rsp_if,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mnet_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [mnet_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [mnet_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import mnet_pkg::*;

   localparam int unsigned IDX_W  = (EVENT_CAPACITY > 1) ? $clog2(EVENT_CAPACITY) : 1;
   localparam int unsigned CNT_W  = $clog2(EVENT_CAPACITY + 1);
   localparam int unsigned LINK_W = IDX_W + TIME_W;
   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(EVENT_CAPACITY);

   // ---------------- configuration registers ----------------
   logic [FILTER_W-1:0] filter_ff;
   logic [SAMPLE_W-1:0] one_sample_ff;
   logic [TIME_W-1:0]   held_dur_ff;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff     <= FILTER_RESET;
         one_sample_ff <= ONE_SAMPLE_RESET;
         held_dur_ff   <= HELD_DUR_RESET;
      end else if (csr_write) begin
         case (csr_reg_type'(csr_paddr[4:3]))
            CSR_CHANNEL_FILTER: filter_ff     <= csr_pwdata[FILTER_W-1:0];
            CSR_ONE_SAMPLE:     one_sample_ff <= csr_pwdata[SAMPLE_W-1:0];
            CSR_HELD_DURATION:  held_dur_ff   <= csr_pwdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg_type'(csr_paddr[4:3]))
         CSR_CHANNEL_FILTER: csr_prdata = CSR_DATA_W'(filter_ff);
         CSR_ONE_SAMPLE:     csr_prdata = CSR_DATA_W'(one_sample_ff);
         CSR_HELD_DURATION:  csr_prdata = CSR_DATA_W'(held_dur_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // ---------------- request capture ----------------
   // Stage flag: a request sits in the compute stage with its link read back.
   logic                busy_ff;
   logic                accept;
   logic                fire;
   logic                rsp_valid_ff;

   logic [3:0]          msg_ff;
   logic [NOTE_W-1:0]   note_ff;
   logic [VEL_W-1:0]    vel_ff;
   logic [CHAN_W-1:0]   chan_ff;
   logic [TIME_W-1:0]   now_ff;

   assign req_if.ready = ~busy_ff;
   assign accept       = req_if.valid & ~busy_ff;
   // compute stage retires once the output register is free or draining
   assign fire         = busy_ff & (~rsp_valid_ff | rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (fire) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         msg_ff  <= req_if.midi_status[7:4];
         note_ff <= req_if.key_byte[NOTE_W-1:0];
         vel_ff  <= req_if.velocity_byte;
         chan_ff <= req_if.midi_channel;
         now_ff  <= req_if.time_beats;
      end
   end

   // ---------------- link memory ----------------
   // Per note: index of the held record and that record's start time. Start
   // time is kept next to the link, since a record is only ever read back
   // through the link of its note. Read on acceptance, written on retire;
   // the two never fall in the same cycle, so no forwarding is needed.
   logic [LINK_W-1:0]     link_mem [NOTE_COUNT];
   logic [LINK_W-1:0]     link_rd_ff;
   logic [NOTE_COUNT-1:0] link_valid_ff;
   logic                  do_record;
   logic                  do_close;
   logic [IDX_W-1:0]      rec_idx;

   always_ff @(posedge clock) begin
      if (accept) begin
         link_rd_ff <= link_mem[req_if.key_byte[NOTE_W-1:0]];
      end
      if (fire && do_record) begin
         link_mem[note_ff] <= {rec_idx, now_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_valid_ff <= '0;
      end else if (fire && do_record) begin
         link_valid_ff[note_ff] <= 1'b1;
      end else if (fire && do_close) begin
         link_valid_ff[note_ff] <= 1'b0;
      end
   end

   // ---------------- record counter ----------------
   logic [CNT_W-1:0] count_ff;

   assign rec_idx = count_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (fire && do_record) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // ---------------- decode and result ----------------
   logic                chan_ok;
   logic                is_on;
   logic                is_off;
   logic                list_full;
   logic [IDX_W-1:0]    link_idx;
   logic [TIME_W-1:0]   link_start;
   logic [TIME_W-1:0]   closed_dur;
   logic [IDX_W-1:0]    sel_idx;
   logic [IDX_W+5:0]    sel_idx_ext;
   logic [FREQ_W-1:0]   freq;
   logic [LEVEL_W-1:0]  level;

   action_type          action_in;
   logic [TIME_W-1:0]   start_in;
   logic [TIME_W-1:0]   dur_in;
   logic [FREQ_W-1:0]   freq_in;
   logic [LEVEL_W-1:0]  level_in;

   assign chan_ok    = (filter_ff == '0) || ({1'b0, chan_ff} + 5'd1 == filter_ff);
   assign is_on      = (msg_ff == MSG_NOTE_ON) && (vel_ff != '0);
   assign is_off     = (msg_ff == MSG_NOTE_OFF) || ((msg_ff == MSG_NOTE_ON) && (vel_ff == '0));
   assign list_full  = (count_ff == CAP_COUNT);
   assign link_idx   = link_rd_ff[LINK_W-1:TIME_W];
   assign link_start = link_rd_ff[TIME_W-1:0];
   assign closed_dur = (now_ff > link_start) ? (now_ff - link_start)
                                             : TIME_W'(one_sample_ff);
   assign freq       = note_freq(note_ff);
   assign level      = vel_level(vel_ff);

   always_comb begin
      do_record = 1'b0;
      do_close  = 1'b0;
      action_in = ACT_IGNORED;
      sel_idx   = '0;
      start_in  = now_ff;
      dur_in    = '0;
      freq_in   = '0;
      level_in  = '0;
      if (chan_ok) begin
         if (is_on) begin
            dur_in   = held_dur_ff;
            freq_in  = freq;
            level_in = level;
            if (!list_full) begin
               do_record = 1'b1;
               action_in = ACT_RECORDED;
               sel_idx   = rec_idx;
            end else begin
               action_in = ACT_DROPPED;
            end
         end else if (is_off && link_valid_ff[note_ff]) begin
            do_close  = 1'b1;
            action_in = ACT_CLOSED;
            sel_idx   = link_idx;
            start_in  = link_start;
            dur_in    = closed_dur;
            freq_in   = freq;
         end
      end
   end

   // event index is reported modulo 64
   assign sel_idx_ext = {6'd0, sel_idx};

   // ---------------- output register ----------------
   action_type          action_ff;
   logic [EVIDX_W-1:0]  evidx_ff;
   logic [TIME_W-1:0]   start_ff;
   logic [TIME_W-1:0]   dur_ff;
   logic [FREQ_W-1:0]   freq_ff;
   logic [LEVEL_W-1:0]  level_ff;
   logic [NOTE_W-1:0]   note_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         action_ff   <= action_in;
         evidx_ff    <= sel_idx_ext[EVIDX_W-1:0];
         start_ff    <= start_in;
         dur_ff      <= dur_in;
         freq_ff     <= freq_in;
         level_ff    <= level_in;
         note_out_ff <= note_ff;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.action         = action_ff;
   assign rsp_if.event_index    = evidx_ff;
   assign rsp_if.start_time     = start_ff;
   assign rsp_if.note_duration  = dur_ff;
   assign rsp_if.frequency_hz   = freq_ff;
   assign rsp_if.velocity_level = level_ff;
   assign rsp_if.note_number    = note_out_ff;

   // ---------------- assertions ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("record count beyond capacity");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("accepted request not held in compute stage");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (fire && do_record) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("record count did not advance on note-on");

   a_retire_valid: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("retired request produced no response");

   a_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && action_ff == ACT_IGNORED) |->
         (freq_ff == '0 && level_ff == '0 && dur_ff == '0))
      else $error("ignored response carries payload");

endmodule

// ===== dv/note_event_monitor.sv =====
// Tracker monitor: mirrors the registers, predicts every response and compares it.
module note_event_monitor
   import mnet_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   mnet_req_if                   req_mon,
   mnet_rsp_if                   rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int unsigned           fail_count,
   output int unsigned           pending_count,
   output int unsigned           recorded_count,
   output int unsigned           dropped_count,
   output int unsigned           closed_count,
   output int unsigned           ignored_count
);

   localparam int unsigned TRACK_CAPACITY = 64;

   typedef struct packed {
      action_type          action;
      logic [EVIDX_W-1:0]  event_index;
      logic [TIME_W-1:0]   start_time;
      logic [TIME_W-1:0]   note_duration;
      logic [FREQ_W-1:0]   frequency_hz;
      logic [LEVEL_W-1:0]  velocity_level;
      logic [NOTE_W-1:0]   note_number;
   } note_result_type;

   logic [FILTER_W-1:0] channel_sel;
   logic [SAMPLE_W-1:0] sample_beats;
   logic [TIME_W-1:0]   held_sentinel;
   logic                link_live [NOTE_COUNT];
   int unsigned         link_slot [NOTE_COUNT];
   logic [TIME_W-1:0]   slot_start [TRACK_CAPACITY];
   int unsigned         slots_used;
   note_result_type     expected_q [$];
   int unsigned         mismatches;
   int unsigned         tally [4];

   // top octave, notes 120..131, Q14.16
   function automatic logic [FREQ_W-1:0] pitch_q16(input logic [NOTE_W-1:0] note);
      logic [63:0] t;
      int unsigned shift;
      shift = 10 - note / 12;
      case (note % 12)
         0:       t = 64'd548668578;
         1:       t = 64'd581294109;
         2:       t = 64'd615859655;
         3:       t = 64'd652480576;
         4:       t = 64'd691279090;
         5:       t = 64'd732384684;
         6:       t = 64'd775934544;
         7:       t = 64'd822074013;
         8:       t = 64'd870957077;
         9:       t = 64'd922746880;
         10:      t = 64'd977616265;
         default: t = 64'd1035748353;
      endcase
      if (shift > 0) begin
         t = (t + (64'd1 << (shift - 1))) >> shift;
      end
      return t[FREQ_W-1:0];
   endfunction

   function automatic logic [LEVEL_W-1:0] level_q15(input logic [VEL_W-1:0] vel);
      logic [31:0] v;
      v = (32'(vel) * 32'd32768 + 32'd63) / 32'd127;
      return v[LEVEL_W-1:0];
   endfunction

   // applies one event to the mirrored link table and returns its response
   function automatic note_result_type track_event(input logic [STATUS_W-1:0] status,
                                                   input logic [KEY_W-1:0]    key,
                                                   input logic [VEL_W-1:0]    vel,
                                                   input logic [CHAN_W-1:0]   chan,
                                                   input logic [TIME_W-1:0]   now);
      note_result_type   r;
      logic [NOTE_W-1:0] note;
      logic              is_on;
      logic              is_off;
      logic [TIME_W-1:0] start;
      int unsigned       slot;
      note   = key[NOTE_W-1:0];
      is_on  = status[7:4] == MSG_NOTE_ON && vel != '0;
      is_off = status[7:4] == MSG_NOTE_OFF || (status[7:4] == MSG_NOTE_ON && vel == '0);
      r             = '0;
      r.action      = ACT_IGNORED;
      r.start_time  = now;
      r.note_number = note;
      if (channel_sel == '0 || 32'(chan) + 1 == 32'(channel_sel)) begin
         if (is_on) begin
            r.note_duration  = held_sentinel;
            r.frequency_hz   = pitch_q16(note);
            r.velocity_level = level_q15(vel);
            if (slots_used < TRACK_CAPACITY) begin
               slot_start[slots_used] = now;
               link_live[note]        = 1'b1;
               link_slot[note]        = slots_used;
               r.action               = ACT_RECORDED;
               r.event_index          = EVIDX_W'(slots_used);
               slots_used++;
            end else begin
               r.action = ACT_DROPPED;
            end
         end else if (is_off && link_live[note]) begin
            slot            = link_slot[note];
            start           = slot_start[slot];
            link_live[note] = 1'b0;
            r.action        = ACT_CLOSED;
            r.event_index   = EVIDX_W'(slot);
            r.start_time    = start;
            r.note_duration = (now > start) ? now - start : TIME_W'(sample_beats);
            r.frequency_hz  = pitch_q16(note);
         end
      end
      return r;
   endfunction

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      note_result_type want;
      note_result_type seen;
      if (reset) begin
         channel_sel   = 5'd0;
         sample_beats  = 25'd699;
         held_sentinel = 48'hFFFF_FFFF_FFFF;
         for (int i = 0; i < NOTE_COUNT; i++) begin
            link_live[i] = 1'b0;
            link_slot[i] = 0;
         end
         slots_used = 0;
         expected_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_reg_type'(csr_paddr[4:3]))
               CSR_CHANNEL_FILTER: channel_sel   = csr_pwdata[FILTER_W-1:0];
               CSR_ONE_SAMPLE:     sample_beats  = csr_pwdata[SAMPLE_W-1:0];
               CSR_HELD_DURATION:  held_sentinel = csr_pwdata[TIME_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            want = track_event(req_mon.midi_status, req_mon.key_byte, req_mon.velocity_byte,
                               req_mon.midi_channel, req_mon.time_beats);
            tally[want.action]++;
            expected_q.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.action         = action_type'(rsp_mon.action);
            seen.event_index    = rsp_mon.event_index;
            seen.start_time     = rsp_mon.start_time;
            seen.note_duration  = rsp_mon.note_duration;
            seen.frequency_hz   = rsp_mon.frequency_hz;
            seen.velocity_level = rsp_mon.velocity_level;
            seen.note_number    = rsp_mon.note_number;
            if (expected_q.size() == 0) begin
               $display("%0t: response with no request outstanding, action 0x%0h note 0x%0h",
                        $time, seen.action, seen.note_number);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               check_field("action", 64'(want.action), 64'(seen.action));
               check_field("event_index", 64'(want.event_index), 64'(seen.event_index));
               check_field("start_time", 64'(want.start_time), 64'(seen.start_time));
               check_field("note_duration", 64'(want.note_duration), 64'(seen.note_duration));
               check_field("frequency_hz", 64'(want.frequency_hz), 64'(seen.frequency_hz));
               check_field("velocity_level", 64'(want.velocity_level),
                           64'(seen.velocity_level));
               check_field("note_number", 64'(want.note_number), 64'(seen.note_number));
            end
         end
      end
      pending_count  <= expected_q.size();
      fail_count     <= mismatches;
      recorded_count <= tally[ACT_RECORDED];
      dropped_count  <= tally[ACT_DROPPED];
      closed_count   <= tally[ACT_CLOSED];
      ignored_count  <= tally[ACT_IGNORED];
   end

endmodule

// ===== dv/midi_note_event_tracker_top_test.sv =====
// Testbench top: drives MIDI note requests and register writes, gives the verdict.
module midi_note_event_tracker_top_test;
   import mnet_pkg::*;

   // cycles with neither channel moving before the run is declared hung
   localparam int unsigned STALL_LIMIT = 1000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned recorded_count;
   int unsigned dropped_count;
   int unsigned closed_count;
   int unsigned ignored_count;

   // stimulus-side bookkeeping only; prediction lives in the monitor
   logic              steady_mode = 1'b0;  // no idling on either side
   logic [FILTER_W-1:0] filter_now;
   logic [TIME_W-1:0] beat_now;
   logic [NOTE_W-1:0] sounding_notes [$];  // notes we switched on and not yet off
   int unsigned       live_items;          // note requests on an open channel
   int unsigned       raw_items;
   int unsigned       idle_cycles;

   always #2 clock = ~clock;

   mnet_req_if req_if ();
   mnet_rsp_if rsp_if ();

   midi_note_event_tracker_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   note_event_monitor u_note_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .recorded_count (recorded_count),
      .dropped_count  (dropped_count),
      .closed_count   (closed_count),
      .ignored_count  (ignored_count)
   );

   // Response back-pressure: ready is low with a 37 percent chance, never in steady mode.
   always @(posedge clock) begin
      rsp_if.ready <= steady_mode || ($urandom_range(99) >= 37);
   end

   // Hang detection: any accepted request or response restarts the count.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no request or response moved for %0d cycles", $time, STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [TIME_W-1:0] rand_beats();
      return TIME_W'({$urandom(), $urandom()});
   endfunction

   // APB write: setup, then access; the register lands on the access edge.
   // The bus is left selected so a following write can start its setup at once.
   task automatic csr_write(input csr_reg_type which, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({which, 3'b000});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   // Holds off the sender until every request has had its response.
   // The first edge lets the monitor book a request accepted on the current one.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // One request. Random idle cycles go before it; valid stays up across back-to-back
   // requests so it is never lowered and raised within one step.
   task automatic send_event(input logic [STATUS_W-1:0] status, input logic [KEY_W-1:0] key,
                             input logic [VEL_W-1:0] vel, input logic [CHAN_W-1:0] chan,
                             input logic [TIME_W-1:0] beats);
      while (!steady_mode && $urandom_range(99) < 37) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.midi_status   <= status;
      req_if.key_byte      <= key;
      req_if.velocity_byte <= vel;
      req_if.midi_channel  <= chan;
      req_if.time_beats    <= beats;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      raw_items++;
      if ((status[7:4] == MSG_NOTE_ON || status[7:4] == MSG_NOTE_OFF) &&
          (filter_now == '0 || 5'(chan) + 5'd1 == filter_now)) begin
         live_items++;
      end
   endtask

   // Opening set at reset values: range ends, both note-off forms, the floor on
   // equal and backward times, retrigger, unlinked note-offs, other message types.
   task automatic directed_events();
      logic [STATUS_W-1:0] odd_status [8] = '{8'hA3, 8'hB0, 8'hC7, 8'hE0,
                                              8'hF0, 8'hFF, 8'h00, 8'h7F};
      send_event({MSG_NOTE_ON, 4'h0}, 8'h00, 7'd127, 4'd0, 48'h0);
      send_event({MSG_NOTE_ON, 4'hF}, 8'h7F, 7'd1, 4'd15, 48'hFFFF_FFFF_FFFF);
      // key bit 7 must be ignored; full-range duration
      send_event({MSG_NOTE_OFF, 4'h0}, 8'h80, 7'd127, 4'd0, 48'hFFFF_FFFF_FFFF);
      // zero-velocity note-on closes, time ran backwards so the floor applies
      send_event({MSG_NOTE_ON, 4'hF}, 8'hFF, 7'd0, 4'd15, 48'h0);
      // note no longer linked
      send_event({MSG_NOTE_OFF, 4'h0}, 8'h00, 7'd0, 4'd0, 48'd10);
      send_event({MSG_NOTE_ON, 4'h3}, 8'd60, 7'd64, 4'd3, 48'd1000);
      send_event({MSG_NOTE_OFF, 4'h3}, 8'd60, 7'd0, 4'd3, 48'd1000);
      // retrigger: the second record takes the link, the first stays held
      send_event({MSG_NOTE_ON, 4'h5}, 8'd69, 7'd100, 4'd5, 48'd2000);
      send_event({MSG_NOTE_ON, 4'h5}, 8'd69, 7'd50, 4'd5, 48'd3000);
      send_event({MSG_NOTE_OFF, 4'h5}, 8'd69, 7'd64, 4'd5, 48'd5000);
      send_event({MSG_NOTE_OFF, 4'h5}, 8'd69, 7'd64, 4'd5, 48'd6000);
      send_event({MSG_NOTE_ON, 4'hA}, 8'h8C, 7'd85, 4'd10, 48'hAAAA_AAAA_AAAA);
      send_event({MSG_NOTE_OFF, 4'hA}, 8'h0C, 7'd42, 4'd10, 48'h5555_5555_5555);
      send_event({MSG_NOTE_ON, 4'h7}, 8'd100, 7'd2, 4'd7, 48'h5555_5555_5555);
      send_event({MSG_NOTE_OFF, 4'h7}, 8'hE4, 7'd85, 4'd7, 48'hAAAA_AAAA_AAAA);
      for (int i = 0; i < 8; i++) begin
         send_event(odd_status[i], 8'h3C, 7'd100, odd_status[i][3:0], 48'd7000);
      end
   endtask

   // Mostly well-formed on/off pairs with random content; the rest is noise.
   task automatic random_event();
      int unsigned         pick;
      int unsigned         slot;
      logic [STATUS_W-1:0] status;
      logic [KEY_W-1:0]    key;
      logic [VEL_W-1:0]    vel;
      logic [CHAN_W-1:0]   chan;
      logic [3:0]          nibble;
      pick = $urandom_range(99);
      if (pick < 4) begin
         beat_now = rand_beats();
      end else if (pick < 6) begin
         beat_now = '0;
      end else if (pick < 8) begin
         beat_now = '1;
      end else if (pick < 12) begin
         beat_now = beat_now - $urandom_range(5000);   // backwards: duration floor
      end else begin
         beat_now = beat_now + $urandom_range(32'h100000);
      end
      if (filter_now != '0 && filter_now <= 5'd16 && $urandom_range(3) != 0) begin
         chan = CHAN_W'(filter_now - 5'd1);
      end else begin
         chan = CHAN_W'($urandom_range(15));
      end
      key  = {1'($urandom_range(1)), NOTE_W'($urandom_range(127))};
      vel  = VEL_W'($urandom_range(127, 1));
      pick = $urandom_range(99);
      if (pick < 8 || (pick < 12 && sounding_notes.size() == 0)) begin
         status = {MSG_NOTE_ON, chan};
         sounding_notes.push_back(key[NOTE_W-1:0]);
      end else if (pick < 12) begin
         key[NOTE_W-1:0] = sounding_notes[$urandom_range(sounding_notes.size() - 1)];
         status = {MSG_NOTE_ON, chan};
      end else if (pick < 55 && sounding_notes.size() != 0) begin
         slot = $urandom_range(sounding_notes.size() - 1);
         key[NOTE_W-1:0] = sounding_notes[slot];
         sounding_notes.delete(slot);
         if ($urandom_range(9) < 7) begin
            status = {MSG_NOTE_OFF, chan};
            vel    = VEL_W'($urandom_range(127));
         end else begin
            status = {MSG_NOTE_ON, chan};
            vel    = '0;
         end
      end else if (pick < 70) begin
         status = {MSG_NOTE_OFF, chan};
         vel    = VEL_W'($urandom_range(127));
      end else if (pick < 85) begin
         do begin
            nibble = 4'($urandom_range(15));
         end while (nibble == MSG_NOTE_ON || nibble == MSG_NOTE_OFF);
         status = {nibble, 4'($urandom_range(15))};
         vel    = VEL_W'($urandom_range(127));
      end else begin
         status = STATUS_W'($urandom_range(255));
         vel    = VEL_W'($urandom_range(127));
         chan   = CHAN_W'($urandom_range(15));
      end
      send_event(status, key, vel, chan, beat_now);
   endtask

   // One register setting: written while idle, then random traffic until either
   // the note-request budget or the raw cap is reached, then drained.
   task automatic run_phase(input logic [FILTER_W-1:0] filter, input logic [SAMPLE_W-1:0] sample,
                            input logic [TIME_W-1:0] held, input logic steady,
                            input int unsigned budget, input int unsigned cap);
      int unsigned live_base;
      int unsigned raw_base;
      csr_write(CSR_CHANNEL_FILTER, CSR_DATA_W'(filter));
      csr_write(CSR_ONE_SAMPLE, CSR_DATA_W'(sample));
      csr_write(CSR_HELD_DURATION, CSR_DATA_W'(held));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      filter_now  = filter;
      steady_mode <= steady;
      live_base   = live_items;
      raw_base    = raw_items;
      while (live_items - live_base < budget && raw_items - raw_base < cap) begin
         random_event();
      end
      wait_idle();
   endtask

   initial begin
      req_if.valid         <= 1'b0;
      req_if.midi_status   <= '0;
      req_if.key_byte      <= '0;
      req_if.velocity_byte <= '0;
      req_if.midi_channel  <= '0;
      req_if.time_beats    <= '0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      filter_now = '0;
      beat_now   = '0;
      live_items = 0;
      raw_items  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_events();
      wait_idle();

      // The list holds 64 records for the whole run, so it fills partway through
      // and later note-ons come back dropped while held notes still close.
      run_phase(5'd0, 25'd1, 48'd0, 1'b0, 110, 4000);
      run_phase(5'd16, 25'd16777216, 48'hFFFF_FFFF_FFFF, 1'b1, 110, 4000);
      // no channel can match a filter above sixteen
      run_phase(5'd31, SAMPLE_W'($urandom_range(16777216, 1)), rand_beats(), 1'b0, 200, 40);
      run_phase(5'd1, SAMPLE_W'($urandom_range(16777216, 1)), rand_beats(), 1'b0, 140, 4000);
      run_phase(FILTER_W'($urandom_range(15, 2)), 25'd699, 48'hFFFF_FFFF_FFFF, 1'b0, 140, 4000);
      run_phase(5'd0, 25'd16777216, 48'd0, 1'b0, 140, 4000);

      // trailing edges after the drain catch any stray response
      repeat (8) @(posedge clock);
      $display("Sent %0d requests across the opening set and six register settings,",
               raw_items);
      $display("%0d of them note events on an open channel.", live_items);
      $display("Responses: %0d recorded, %0d dropped on a full list, %0d closed, %0d ignored.",
               recorded_count, dropped_count, closed_count, ignored_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
